FILE: rtl/jsu_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jsu_pkg
// Types and constants shared by the JSON string unescaper.
// ----------------------------------------------------------------------------
package jsu_pkg;

	localparam int JOB_BYTES = 6;

	typedef struct packed {
		logic       func;
		logic [7:0] in_byte;
	} in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       has_byte;
		logic       string_done;
		logic       last;
	} out_t;

	// One input word's worth of decoded bytes
	typedef struct packed {
		logic [JOB_BYTES-1:0][7:0] bytes;
		logic [2:0]                cnt;
		logic                      done;
	} job_t;

endpackage : jsu_pkg
`default_nettype wire

FILE: rtl/jsu_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jsu_front
// Escape decoder: tracks the escape state, builds the UTF-8 bytes of each word.
// ----------------------------------------------------------------------------
module jsu_front
	import jsu_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic take,
	input  wire in_t  word,
	output job_t      job,
	output logic      job_nonempty
);

	localparam logic [2:0] M_NORMAL   = 3'd0;
	localparam logic [2:0] M_ESC      = 3'd1;
	localparam logic [2:0] M_HEX1     = 3'd2;
	localparam logic [2:0] M_HIGH     = 3'd3;
	localparam logic [2:0] M_HIGH_BSL = 3'd4;
	localparam logic [2:0] M_HEX2     = 3'd5;

	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_U     = 8'h75;

	typedef struct packed {
		logic [3:0][7:0] b;
		logic [2:0]      len;
	} enc_t;

	function automatic enc_t utf8_enc(input logic [20:0] cp);
		enc_t e;
		e = '0;
		if (cp <= 21'h7F) begin
			e.b[0] = cp[7:0];
			e.len  = 3'd1;
		end else if (cp <= 21'h7FF) begin
			e.b[0] = 8'hC0 | {3'b000, cp[10:6]};
			e.b[1] = 8'h80 | {2'b00, cp[5:0]};
			e.len  = 3'd2;
		end else if (cp <= 21'hFFFF) begin
			e.b[0] = 8'hE0 | {4'h0, cp[15:12]};
			e.b[1] = 8'h80 | {2'b00, cp[11:6]};
			e.b[2] = 8'h80 | {2'b00, cp[5:0]};
			e.len  = 3'd3;
		end else begin
			e.b[0] = 8'hF0 | {5'h00, cp[20:18]};
			e.b[1] = 8'h80 | {2'b00, cp[17:12]};
			e.b[2] = 8'h80 | {2'b00, cp[11:6]};
			e.b[3] = 8'h80 | {2'b00, cp[5:0]};
			e.len  = 3'd4;
		end
		return e;
	endfunction

	function automatic logic [3:0] nibble_val(input logic [7:0] c);
		logic [3:0] d;
		d = 4'h0;
		if (c >= 8'h30 && c <= 8'h39)      d = 4'(c - 8'h30);
		else if (c >= 8'h61 && c <= 8'h66) d = 4'(c - 8'h57);
		else if (c >= 8'h41 && c <= 8'h46) d = 4'(c - 8'h37);
		return d;
	endfunction

	function automatic logic [7:0] esc_char(input logic [7:0] c);
		logic [7:0] r;
		unique case (c)
			8'h62:   r = 8'h08;
			8'h66:   r = 8'h0C;
			8'h6E:   r = 8'h0A;
			8'h72:   r = 8'h0D;
			8'h74:   r = 8'h09;
			default: r = c;
		endcase
		return r;
	endfunction

	logic [2:0]  mode_q, mode_d;
	logic [1:0]  hcnt_q, hcnt_d;
	logic [15:0] hval_q, hval_d;
	logic [15:0] high_q, high_d;

	logic        v0, v1, vr, done;
	logic [20:0] cp0;
	logic [15:0] cp1;
	logic [7:0]  raw;
	logic [7:0]  b;
	logic [15:0] nv;
	logic        full4;
	enc_t        e0, e1;
	logic [2:0]  l0, l1, kk, j;

	assign b     = word.in_byte;
	assign nv    = {hval_q[11:0], nibble_val(b)};
	assign full4 = (hcnt_q == 2'd3);

	always_comb begin
		mode_d = mode_q;
		hcnt_d = hcnt_q;
		hval_d = hval_q;
		high_d = high_q;
		v0     = 1'b0;
		v1     = 1'b0;
		vr     = 1'b0;
		done   = 1'b0;
		cp0    = '0;
		cp1    = '0;
		raw    = b;
		if (word.func) begin
			done = 1'b1;
			unique case (mode_q)
				M_HEX1: begin
					v0  = 1'b1;
					cp0 = {5'h00, hval_q};
				end
				M_HIGH, M_HIGH_BSL: begin
					v0  = 1'b1;
					cp0 = {5'h00, high_q};
				end
				M_HEX2: begin
					v0  = 1'b1;
					cp0 = {5'h00, high_q};
					v1  = 1'b1;
					cp1 = hval_q;
				end
				default: ;
			endcase
		end else begin
			unique case (mode_q)
				M_ESC, M_HIGH_BSL: begin
					if (mode_q == M_HIGH_BSL && b != CH_U) begin
						v0  = 1'b1;
						cp0 = {5'h00, high_q};
					end
					if (b == CH_U) begin
						mode_d = (mode_q == M_ESC) ? M_HEX1 : M_HEX2;
						hcnt_d = 2'd0;
						hval_d = 16'h0000;
					end else begin
						mode_d = M_NORMAL;
						vr     = 1'b1;
						raw    = esc_char(b);
					end
				end
				M_HEX1: begin
					hval_d = nv;
					if (!full4) begin
						hcnt_d = hcnt_q + 2'd1;
					end else if (nv >= 16'hD800 && nv <= 16'hDBFF) begin
						high_d = nv;
						mode_d = M_HIGH;
					end else begin
						v0     = 1'b1;
						cp0    = {5'h00, nv};
						mode_d = M_NORMAL;
					end
				end
				M_HEX2: begin
					hval_d = nv;
					if (!full4) begin
						hcnt_d = hcnt_q + 2'd1;
					end else begin
						mode_d = M_NORMAL;
						v0     = 1'b1;
						if (nv >= 16'hDC00 && nv <= 16'hDFFF) begin
							cp0 = 21'h10000 + {1'b0, high_q[9:0], nv[9:0]};
						end else begin
							cp0 = {5'h00, high_q};
							v1  = 1'b1;
							cp1 = nv;
						end
					end
				end
				default: begin
					// Normal text, or the byte that follows a completed high surrogate
					if (mode_q == M_HIGH && b == CH_BSL) begin
						mode_d = M_HIGH_BSL;
					end else begin
						if (mode_q == M_HIGH) begin
							v0  = 1'b1;
							cp0 = {5'h00, high_q};
						end
						mode_d = M_NORMAL;
						if (b == CH_QUOTE)    done   = 1'b1;
						else if (b == CH_BSL) mode_d = M_ESC;
						else                  vr     = 1'b1;
					end
				end
			endcase
		end
		if (done) begin
			mode_d = M_NORMAL;
			hcnt_d = 2'd0;
			hval_d = 16'h0000;
			high_d = 16'h0000;
		end
	end

	assign e0 = utf8_enc(cp0);
	assign e1 = utf8_enc({5'h00, cp1});
	assign l0 = v0 ? e0.len : 3'd0;
	assign l1 = v1 ? e1.len : 3'd0;

	always_comb begin
		job.done = done;
		job.cnt  = l0 + l1 + {2'b00, vr};
		kk       = 3'd0;
		j        = 3'd0;
		for (int k = 0; k < JOB_BYTES; k++) begin
			kk = 3'(k);
			j  = kk - l0;
			if (kk < l0)     job.bytes[k] = e0.b[kk[1:0]];
			else if (j < l1) job.bytes[k] = e1.b[j[1:0]];
			else             job.bytes[k] = raw;
		end
	end

	assign job_nonempty = (job.cnt != 3'd0) || done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_NORMAL;
			hcnt_q <= 2'd0;
			hval_q <= 16'h0000;
			high_q <= 16'h0000;
		end else if (take) begin
			mode_q <= mode_d;
			hcnt_q <= hcnt_d;
			hval_q <= hval_d;
			high_q <= high_d;
		end
	end

endmodule : jsu_front
`default_nettype wire

FILE: rtl/jsu_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jsu_queue
// Short register queue of decoded jobs between decoder and serialiser.
// ----------------------------------------------------------------------------
module jsu_queue
	import jsu_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire job_t push_job,
	output logic      full,
	input  wire logic pop,
	output logic      head_valid,
	output job_t      head_job
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	job_t          mem_q [DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;
	logic          do_push, do_pop;

	assign full       = (cnt_q == CW'(DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head_job   = mem_q[rd_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
			if (do_pop)  rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
			if (do_push && !do_pop)      cnt_q <= cnt_q + CW'(1);
			else if (do_pop && !do_push) cnt_q <= cnt_q - CW'(1);
		end
	end

endmodule : jsu_queue
`default_nettype wire

FILE: rtl/jsu_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jsu_back
// Serialiser: job bytes to the output register, one word per cycle when ready.
// ----------------------------------------------------------------------------
module jsu_back
	import jsu_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic head_valid,
	input  wire job_t head_job,
	output logic      pop,
	output logic      utf_valid,
	input  wire logic utf_ready,
	output out_t      utf_word
);

	logic [2:0] idx_q;
	logic       ov_q;
	out_t       word_q;
	logic       adv, fin;
	out_t       nxt;

	assign adv = head_valid && (!ov_q || utf_ready);
	assign fin = (head_job.cnt == 3'd0) || (idx_q == head_job.cnt - 3'd1);
	assign pop = adv && fin;

	always_comb begin
		nxt.has_byte    = (head_job.cnt != 3'd0);
		nxt.out_byte    = nxt.has_byte ? head_job.bytes[idx_q] : 8'h00;
		nxt.string_done = head_job.done && fin;
		nxt.last        = fin;
	end

	always_ff @(posedge clk) begin
		if (adv) word_q <= nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= 3'd0;
			ov_q  <= 1'b0;
		end else begin
			if (adv)            ov_q <= 1'b1;
			else if (utf_ready) ov_q <= 1'b0;
			if (adv) idx_q <= fin ? 3'd0 : idx_q + 3'd1;
		end
	end

	assign utf_valid = ov_q;
	assign utf_word  = word_q;

endmodule : jsu_back
`default_nettype wire

FILE: rtl/json_string_unescape_utf8_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_top
// JSON string body unescaper with UTF-8 output.
// ----------------------------------------------------------------------------
// Takes one escaped string byte (or an end-of-source word) per cycle and
// returns the decoded bytes, one output word per cycle while the output is
// accepted, the final word of each input marked with last. The decoder takes
// a new input word every cycle while the job queue has room; each input word
// yields one output word per decoded byte (one word with no byte when it yields
// none but ends the string, none when it yields nothing), so sustained rate is
// one input per cycle for plain text and up to six output words per input
// where a surrogate pair or unpaired value is flushed. The output serialiser
// sets the pace; QUEUE_DEPTH jobs of slack sit between the two sides.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8_top
	import jsu_pkg::*;
#(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic esc_valid,
	output logic      esc_ready,
	input  wire in_t  esc_word,
	output logic      utf_valid,
	input  wire logic utf_ready,
	output out_t      utf_word
);

	job_t job, head_job;
	logic job_nonempty, full, head_valid, pop, take;

	assign esc_ready = !full;
	assign take      = esc_valid && esc_ready;

	jsu_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.take         (take),
		.word         (esc_word),
		.job          (job),
		.job_nonempty (job_nonempty)
	);

	jsu_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (take && job_nonempty),
		.push_job   (job),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_job   (head_job)
	);

	jsu_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_job   (head_job),
		.pop        (pop),
		.utf_valid  (utf_valid),
		.utf_ready  (utf_ready),
		.utf_word   (utf_word)
	);

endmodule : json_string_unescape_utf8_top
`default_nettype wire

FILE: tb/tb_json_string_unescape_utf8_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_json_string_unescape_utf8_top
// Self-checking bench for the JSON string unescaper with UTF-8 output.
// ----------------------------------------------------------------------------
// A short table of hand-picked words comes first: edge bytes, simple and
// unknown escapes, a literal quote, the largest surrogate pair, a dropped
// backslash and empty strings. The table is followed by a few hundred words
// built from escape sequences with random content: \u values of every length,
// surrogate pairs, broken pairs, lone halves, bad hex digits, quotes inside
// digits and strings cut short by a source end. Each accepted input word is
// run through a behavioural decoder in the bench; its output words (the table's
// word for a typed row) are queued and compared field by field with the output.
// Both sides stall at random, with one calm stretch and one long output hold.
// ----------------------------------------------------------------------------
module tb_json_string_unescape_utf8_top;
	import jsu_pkg::*;

	localparam int DIR_N = 24;
	localparam int RAND_ITEMS = 386;
	localparam int WD_LIMIT = 2000;

	localparam logic FN_BYTE = 1'b0;
	localparam logic FN_END = 1'b1;

	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSL = 8'h5C;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_B = 8'h62;
	localparam logic [7:0] CH_F = 8'h66;
	localparam logic [7:0] CH_N = 8'h6E;
	localparam logic [7:0] CH_R = 8'h72;
	localparam logic [7:0] CH_T = 8'h74;
	localparam logic [7:0] CH_U = 8'h75;
	localparam logic [7:0] CH_Q = 8'h71;

	localparam logic [7:0] SIMPLE_ESC [8] = '{CH_QUOTE, CH_BSL, CH_SLASH, CH_B,
		CH_F, CH_N, CH_R, CH_T};

	typedef enum logic [2:0] {
		DS_TEXT, DS_ESC, DS_HEX, DS_HIGH, DS_HIGH_BSL, DS_LOW_HEX
	} dec_state_t;

	typedef struct packed {
		logic       func;
		logic [7:0] b;
		logic       typed;
		logic [7:0] eb;
		logic       ehas;
		logic       edone;
	} dir_row_t;

	typedef struct {
		in_t  w;
		logic typed;
		out_t want;
	} stim_t;

	// typed rows carry their single expected word; others get the decoder's words
	localparam dir_row_t DIR_TAB [DIR_N] = '{
		'{FN_END,  8'hFF,    1'b1, 8'h00, 1'b0, 1'b1},
		'{FN_BYTE, 8'h00,    1'b1, 8'h00, 1'b1, 1'b0},
		'{FN_BYTE, 8'hFF,    1'b1, 8'hFF, 1'b1, 1'b0},
		'{FN_BYTE, CH_BSL,   1'b0, 8'h00, 1'b0, 1'b0},
		'{FN_BYTE, CH_N,     1'b1, 8'h0A, 1'b1, 1'b0},
		'{FN_BYTE, CH_BSL,   1'b0, 8'h00, 1'b0, 1'b0},
		'{FN_BYTE, CH_Q,     1'b1, CH_Q,  1'b1, 1'b0},
		'{FN_BYTE, CH_BSL,   1'b0, 8'h00, 1'b0, 1'b0},
		'{FN_BYTE, CH_QUOTE, 1'b1, CH_QUOTE, 1'b1, 1'b0},
		'{FN_BYTE, CH_BSL,   1'b0, 8'h00, 1'b0, 1'b0},
		'{FN_BYTE, CH_U,     1'b0, 8'h00, 1'b0, 1'b0},
		'{FN_BYTE, "D",      1'b0, 8'h00, 1'b0, 1'b0},
		'{FN_BYTE, "b",      1'b0, 8'h00, 1'b0, 1'b0},
		'{FN_BYTE, "F",      1'b0, 8'h00, 1'b0, 1'b0},
		'{FN_BYTE, "f",      1'b0, 8'h00, 1'b0, 1'b0},
		'{FN_BYTE, CH_BSL,   1'b0, 8'h00, 1'b0, 1'b0},
		'{FN_BYTE, CH_U,     1'b0, 8'h00, 1'b0, 1'b0},
		'{FN_BYTE, "d",      1'b0, 8'h00, 1'b0, 1'b0},
		'{FN_BYTE, "F",      1'b0, 8'h00, 1'b0, 1'b0},
		'{FN_BYTE, "F",      1'b0, 8'h00, 1'b0, 1'b0},
		'{FN_BYTE, "F",      1'b0, 8'h00, 1'b0, 1'b0},
		'{FN_BYTE, CH_BSL,   1'b0, 8'h00, 1'b0, 1'b0},
		'{FN_END,  8'h00,    1'b1, 8'h00, 1'b0, 1'b1},
		'{FN_BYTE, CH_QUOTE, 1'b1, 8'h00, 1'b0, 1'b1}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic esc_valid = 1'b0;
	logic esc_ready;
	in_t  esc_word = '0;
	logic utf_valid;
	logic utf_ready = 1'b0;
	out_t utf_word;

	stim_t stim[$];
	in_t   frag[$];
	out_t  step_out[$];
	out_t  decoded_due[$];

	dec_state_t  dec_st = DS_TEXT;
	logic [1:0]  hex_n = '0;
	logic [15:0] hex_acc = '0;
	logic [15:0] hi_sur = '0;

	int send_idx = 0;
	int acc_idx = 0;
	int hold_cnt = 0;
	bit held = 1'b0;
	int stall_cyc = 0;
	int fault_cnt = 0;
	int out_total = 0;
	int str_total = 0;
	int pair_total = 0;

	wire calm = (send_idx >= DIR_N + 150) && (send_idx < DIR_N + 260);

	json_string_unescape_utf8_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.esc_valid (esc_valid),
		.esc_ready (esc_ready),
		.esc_word  (esc_word),
		.utf_valid (utf_valid),
		.utf_ready (utf_ready),
		.utf_word  (utf_word)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	task automatic flag_fault(input string msg);
		fault_cnt++;
		if (fault_cnt <= 40)
			$display("ERROR: %s", msg);
	endtask

	// ---------------- decoder model ----------------

	function automatic logic [3:0] nib_of(input logic [7:0] c);
		if (c >= "0" && c <= "9")
			return 4'(c - "0");
		if (c >= "a" && c <= "f")
			return 4'(c - "a" + 8'd10);
		if (c >= "A" && c <= "F")
			return 4'(c - "A" + 8'd10);
		return 4'h0;
	endfunction

	task automatic emit_byte(input logic [7:0] b);
		out_t r;
		r = '{out_byte: b, has_byte: 1'b1, string_done: 1'b0, last: 1'b0};
		if (step_out.size() < JOB_BYTES)
			step_out.insert(step_out.size(), r);
	endtask

	task automatic emit_cp(input logic [20:0] cp);
		if (cp <= 21'h7F) begin
			emit_byte(cp[7:0]);
		end else if (cp <= 21'h7FF) begin
			emit_byte({3'b110, cp[10:6]});
			emit_byte({2'b10, cp[5:0]});
		end else if (cp <= 21'hFFFF) begin
			emit_byte({4'b1110, cp[15:12]});
			emit_byte({2'b10, cp[11:6]});
			emit_byte({2'b10, cp[5:0]});
		end else begin
			emit_byte({5'b11110, cp[20:18]});
			emit_byte({2'b10, cp[17:12]});
			emit_byte({2'b10, cp[11:6]});
			emit_byte({2'b10, cp[5:0]});
		end
	endtask

	task automatic text_byte(input logic [7:0] b, inout bit done);
		dec_st = DS_TEXT;
		if (b == CH_QUOTE)
			done = 1'b1;
		else if (b == CH_BSL)
			dec_st = DS_ESC;
		else
			emit_byte(b);
	endtask

	task automatic esc_byte(input logic [7:0] b);
		logic [7:0] c;
		c = b;
		dec_st = DS_TEXT;
		case (b)
			CH_B: c = 8'h08;
			CH_F: c = 8'h0C;
			CH_N: c = 8'h0A;
			CH_R: c = 8'h0D;
			CH_T: c = 8'h09;
			CH_U: begin
				dec_st = DS_HEX;
				hex_n = '0;
				hex_acc = '0;
			end
			default: ;
		endcase
		if (dec_st != DS_HEX)
			emit_byte(c);
	endtask

	task automatic take_hex(input logic [7:0] b, output bit full);
		hex_acc = {hex_acc[11:0], nib_of(b)};
		full = (hex_n == 2'd3);
		if (!full)
			hex_n = hex_n + 2'd1;
	endtask

	task automatic unescape_word(input in_t w);
		bit done;
		bit full;
		logic [20:0] cp;
		done = 1'b0;
		step_out.delete();
		if (w.func == FN_END) begin
			case (dec_st)
				DS_HEX: emit_cp({5'd0, hex_acc});
				DS_HIGH, DS_HIGH_BSL: emit_cp({5'd0, hi_sur});
				DS_LOW_HEX: begin
					emit_cp({5'd0, hi_sur});
					emit_cp({5'd0, hex_acc});
				end
				default: ;
			endcase
			done = 1'b1;
		end else begin
			case (dec_st)
				DS_ESC: esc_byte(w.in_byte);
				DS_HEX: begin
					take_hex(w.in_byte, full);
					if (full) begin
						if (hex_acc >= 16'hD800 && hex_acc <= 16'hDBFF) begin
							hi_sur = hex_acc;
							dec_st = DS_HIGH;
						end else begin
							emit_cp({5'd0, hex_acc});
							dec_st = DS_TEXT;
						end
					end
				end
				DS_HIGH: begin
					if (w.in_byte == CH_BSL) begin
						dec_st = DS_HIGH_BSL;
					end else begin
						emit_cp({5'd0, hi_sur});
						text_byte(w.in_byte, done);
					end
				end
				DS_HIGH_BSL: begin
					if (w.in_byte == CH_U) begin
						dec_st = DS_LOW_HEX;
						hex_n = '0;
						hex_acc = '0;
					end else begin
						emit_cp({5'd0, hi_sur});
						esc_byte(w.in_byte);
					end
				end
				DS_LOW_HEX: begin
					take_hex(w.in_byte, full);
					if (full) begin
						if (hex_acc >= 16'hDC00 && hex_acc <= 16'hDFFF) begin
							cp = 21'h10000 + (({5'd0, hi_sur} - 21'h0D800) << 10)
								+ ({5'd0, hex_acc} - 21'h0DC00);
							emit_cp(cp);
							pair_total++;
						end else begin
							emit_cp({5'd0, hi_sur});
							emit_cp({5'd0, hex_acc});
						end
						dec_st = DS_TEXT;
					end
				end
				default: text_byte(w.in_byte, done);
			endcase
		end
		if (done) begin
			dec_st = DS_TEXT;
			hex_n = '0;
			hex_acc = '0;
			hi_sur = '0;
			if (step_out.size() == 0)
				step_out.insert(0, '{out_byte: 8'h00, has_byte: 1'b0, string_done: 1'b0,
					last: 1'b0});
		end
		if (step_out.size() > 0) begin
			step_out[step_out.size() - 1].last = 1'b1;
			if (done)
				step_out[step_out.size() - 1].string_done = 1'b1;
		end
	endtask

	// ---------------- stimulus building ----------------

	task automatic frag_byte(input logic [7:0] b);
		frag.insert(frag.size(), '{func: FN_BYTE, in_byte: b});
	endtask

	function automatic logic [7:0] hex_char(input logic [3:0] n, input bit upper);
		if (n < 4'd10)
			return "0" + 8'(n);
		return (upper ? "A" : "a") + 8'(n) - 8'd10;
	endfunction

	// digits of a \u value; now and then a digit is spoilt, often by a quote
	task automatic frag_hex(input logic [15:0] v);
		logic [7:0] c;
		for (int i = 3; i >= 0; i--) begin
			c = hex_char(v[i*4 +: 4], bit'($urandom_range(0, 1)));
			if ($urandom_range(0, 11) == 0)
				c = $urandom_range(0, 1) ? CH_QUOTE : 8'($urandom_range(0, 255));
			frag_byte(c);
		end
	endtask

	task automatic frag_high();
		frag_byte(CH_BSL);
		frag_byte(CH_U);
		frag_hex(16'hD800 + 16'($urandom_range(0, 16'h3FF)));
	endtask

	// ---------------- drivers ----------------

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esc_valid <= 1'b0;
			esc_word <= '0;
		end else if (!esc_valid || esc_ready) begin
			if (send_idx < stim.size()
					&& (calm || hold_cnt > 0 || $urandom_range(0, 99) >= 36)) begin
				esc_valid <= 1'b1;
				esc_word <= stim[send_idx].w;
				send_idx++;
			end else begin
				esc_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			utf_ready <= 1'b0;
			hold_cnt = 0;
			held = 1'b0;
		end else begin
			if (!held && acc_idx >= DIR_N + 40) begin
				held = 1'b1;
				hold_cnt = 80;
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				utf_ready <= 1'b0;
			end else begin
				utf_ready <= calm || ($urandom_range(0, 99) >= 36);
			end
		end
	end

	// ---------------- predict and check ----------------

	always @(posedge clk) begin
		out_t want;
		bit busy;
		busy = 1'b0;
		if (arst_n) begin
			if (esc_valid && esc_ready) begin
				busy = 1'b1;
				unescape_word(esc_word);
				if (stim[acc_idx].typed) begin
					step_out.delete();
					step_out.insert(0, stim[acc_idx].want);
				end
				foreach (step_out[i])
					decoded_due.insert(decoded_due.size(), step_out[i]);
				acc_idx++;
			end
			if (utf_valid && utf_ready) begin
				busy = 1'b1;
				out_total++;
				if (decoded_due.size() == 0) begin
					flag_fault($sformatf("unexpected output word %h", utf_word));
				end else begin
					want = decoded_due.pop_front();
					if (utf_word.out_byte !== want.out_byte
							|| utf_word.has_byte !== want.has_byte
							|| utf_word.string_done !== want.string_done
							|| utf_word.last !== want.last)
						flag_fault($sformatf(
							"out %0d: byte %h has %b done %b last %b, want %h %b %b %b",
							out_total, utf_word.out_byte, utf_word.has_byte,
							utf_word.string_done, utf_word.last, want.out_byte,
							want.has_byte, want.string_done, want.last));
					if (want.string_done)
						str_total++;
				end
			end
			stall_cyc = busy ? 0 : stall_cyc + 1;
		end
	end

	initial begin
		wait (stall_cyc >= WD_LIMIT);
		$display("ERROR: no word moved for %0d cycles", WD_LIMIT);
		$display("CHECK FAILED");
		$finish;
	end

	// ---------------- main sequence ----------------

	initial begin
		dir_row_t    row;
		logic [7:0]  b;
		logic [15:0] v;
		int          keep;

		for (int i = 0; i < DIR_N; i++) begin
			row = DIR_TAB[i];
			stim.insert(stim.size(), '{w: '{func: row.func, in_byte: row.b},
				typed: row.typed,
				want: '{out_byte: row.eb, has_byte: row.ehas, string_done: row.edone,
				last: 1'b1}});
		end

		while (stim.size() < DIR_N + RAND_ITEMS) begin
			frag.delete();
			case ($urandom_range(0, 12))
				0, 1: begin
					repeat ($urandom_range(1, 4)) begin
						b = 8'($urandom_range(0, 255));
						if (b == CH_QUOTE || b == CH_BSL)
							b = b ^ 8'h01;
						frag_byte(b);
					end
				end
				2: begin
					frag_byte(CH_BSL);
					frag_byte(SIMPLE_ESC[$urandom_range(0, 7)]);
				end
				3: begin
					frag_byte(CH_BSL);
					frag_byte(8'($urandom_range(0, 255)));
				end
				4, 5: begin
					case ($urandom_range(0, 3))
						0: v = 16'($urandom_range(0, 16'h7F));
						1: v = 16'($urandom_range(16'h80, 16'h7FF));
						2: v = 16'($urandom_range(16'h800, 16'hFFFF));
						default: v = 16'($urandom_range(16'hDC00, 16'hDFFF));
					endcase
					if ($urandom_range(0, 15) == 0)
						v = $urandom_range(0, 1) ? 16'h0000 : 16'hFFFF;
					frag_byte(CH_BSL);
					frag_byte(CH_U);
					frag_hex(v);
				end
				6, 7: begin
					frag_high();
					frag_byte(CH_BSL);
					frag_byte(CH_U);
					frag_hex(16'hDC00 + 16'($urandom_range(0, 16'h3FF)));
				end
				8: begin
					frag_high();
					case ($urandom_range(0, 2))
						0: begin
							b = 8'($urandom_range(0, 255));
							if (b == CH_BSL)
								b = CH_Q;
							frag_byte(b);
						end
						1: begin
							frag_byte(CH_BSL);
							b = 8'($urandom_range(0, 255));
							if (b == CH_U)
								b = CH_N;
							frag_byte(b);
						end
						default: frag_byte(CH_QUOTE);
					endcase
				end
				9: begin
					frag_high();
					v = 16'($urandom_range(0, 16'hFFFF));
					if (v[15:10] == 6'b110111)
						v[10] = 1'b0;
					frag_byte(CH_BSL);
					frag_byte(CH_U);
					frag_hex(v);
				end
				10: frag_byte(CH_QUOTE);
				11: frag.insert(frag.size(),
					'{func: FN_END, in_byte: 8'($urandom_range(0, 255))});
				default: frag_byte(8'($urandom_range(0, 255)));
			endcase
			// cut the sequence short with a source end
			if (frag.size() > 1 && $urandom_range(0, 7) == 0) begin
				keep = $urandom_range(1, frag.size() - 1);
				while (frag.size() > keep)
					frag.delete(frag.size() - 1);
				frag.insert(frag.size(),
					'{func: FN_END, in_byte: 8'($urandom_range(0, 255))});
			end
			foreach (frag[i])
				stim.insert(stim.size(), '{w: frag[i], typed: 1'b0, want: '0});
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		while (acc_idx < stim.size() || decoded_due.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (decoded_due.size() != 0)
			flag_fault($sformatf("%0d output words never arrived", decoded_due.size()));

		$display("Run: %0d input words (%0d from the directed table), %0d output words",
			acc_idx, DIR_N, out_total);
		$display("Run: %0d strings closed, %0d surrogate pairs joined, %0d faults",
			str_total, pair_total, fault_cnt);
		if (fault_cnt == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
